// ===== src/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, command and status codes, and request/response types
// for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 6;
  localparam int ECNT_W  = 7;
  localparam int DATA_W  = 32;
  localparam int CMP_W   = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_READ   = 3'd1,
    CMD_EDIT   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_SORT   = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] data_value;
  } ile_req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_data;
    logic [POS_W-1:0]         found_position;
    logic [ECNT_W-1:0]        entry_count;
  } ile_rsp_t;

endpackage

// ===== src/ile_if.sv =====
// ----------------------------------------------------------------------------
// ile_if
// Valid/ready channels for indexed list engine requests and responses.
// ----------------------------------------------------------------------------
interface ile_in_if;
  logic             valid;
  logic             ready;
  ile_pkg::ile_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ile_out_if;
  logic             valid;
  logic             ready;
  ile_pkg::ile_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/indexed_list_engine.sv =====
// Edit, bad index, full, unused codes and sort of fewer than two entries answer
// directly; insert at the end and remove of the last entry go through the tail
// state; read, other inserts and removes, and search of a non-empty list scan first.
// Sort makes count - 1 passes, each one entry shorter than the last.
// One request at a time: the next is taken the cycle after its response is loaded.
// Reset (synchronous, rst_n low) empties the list; the store is not cleared.
// ----------------------------------------------------------------------------
// indexed_list_engine
// Packed list of signed entries in a synchronous memory with insert, read,
// edit, remove, search and sort, streamed one entry per cycle.
// ----------------------------------------------------------------------------
module indexed_list_engine (
  input logic       clk,
  input logic       rst_n,
  ile_in_if.sink    in_req,
  ile_out_if.source out_rsp
);
  import ile_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  logic [DATA_W-1:0] entry_mem_r [DEPTH];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  plen_r, plen_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic              issue_r, issue_nxt;
  logic              rvld_r, rvld_nxt;
  logic [ADDR_W-1:0] raddr_r, raddr_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] carry_r, carry_nxt;
  logic              found_r, found_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_rdata_r, res_rdata_nxt;
  logic [ADDR_W-1:0] res_fpos_r, res_fpos_nxt;
  logic              out_valid_r, out_valid_nxt;
  ile_rsp_t          out_r, out_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;

  logic [CMP_W-1:0]  req_pos_w;
  logic [CMP_W-1:0]  cnt_w;

  assign req_pos_w = CMP_W'(in_req.payload.position);
  assign cnt_w     = CMP_W'(cnt_r);

  assign in_req.ready    = (state_r == S_IDLE);
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = out_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    plen_nxt       = plen_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    scan_nxt       = scan_r;
    last_nxt       = last_r;
    issue_nxt      = issue_r;
    rvld_nxt       = 1'b0;
    raddr_nxt      = scan_r;
    carry_nxt      = carry_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_rdata_nxt  = res_rdata_r;
    res_fpos_nxt   = res_fpos_r;
    out_valid_nxt  = out_valid_r & ~out_rsp.ready;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = key_r;
    mem_re         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt         = in_req.payload.command;
          pos_nxt        = ADDR_W'(in_req.payload.position);
          key_nxt        = in_req.payload.data_value;
          found_nxt      = 1'b0;
          res_status_nxt = ST_OK;
          res_rdata_nxt  = '0;
          res_fpos_nxt   = '0;
          state_nxt      = S_RESP;
          unique case (in_req.payload.command)
            CMD_INSERT: begin
              if (req_pos_w > cnt_w) begin
                res_status_nxt = ST_BAD_INDEX;
              end else if (cnt_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else if (req_pos_w == cnt_w) begin
                state_nxt = S_TAIL;
              end else begin
                scan_nxt  = ADDR_W'(cnt_r - CNT_W'(1));
                last_nxt  = ADDR_W'(in_req.payload.position);
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            CMD_READ: begin
              if (req_pos_w >= cnt_w) begin
                res_status_nxt = ST_BAD_INDEX;
              end else begin
                scan_nxt  = ADDR_W'(in_req.payload.position);
                last_nxt  = ADDR_W'(in_req.payload.position);
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            CMD_EDIT: begin
              if (req_pos_w >= cnt_w) begin
                res_status_nxt = ST_BAD_INDEX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(in_req.payload.position);
                mem_wdata = in_req.payload.data_value;
              end
            end
            CMD_REMOVE: begin
              if (req_pos_w >= cnt_w) begin
                res_status_nxt = ST_BAD_INDEX;
              end else if (req_pos_w + CMP_W'(1) == cnt_w) begin
                state_nxt = S_TAIL;
              end else begin
                scan_nxt  = ADDR_W'(in_req.payload.position) + ADDR_W'(1);
                last_nxt  = ADDR_W'(cnt_r - CNT_W'(1));
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            CMD_SEARCH: begin
              if (cnt_r == '0) begin
                state_nxt = S_TAIL;
              end else begin
                scan_nxt  = '0;
                last_nxt  = ADDR_W'(cnt_r - CNT_W'(1));
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            CMD_SORT: begin
              if (cnt_r >= CNT_W'(2)) begin
                plen_nxt  = cnt_r;
                scan_nxt  = '0;
                last_nxt  = ADDR_W'(cnt_r - CNT_W'(1));
                issue_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // one read issued and one returned entry handled per cycle
        mem_re   = issue_r;
        rvld_nxt = issue_r;
        if (issue_r) begin
          if (scan_r == last_r) begin
            issue_nxt = 1'b0;
          end else if (op_r == CMD_INSERT) begin
            scan_nxt = scan_r - ADDR_W'(1);
          end else begin
            scan_nxt = scan_r + ADDR_W'(1);
          end
        end
        if (rvld_r) begin
          unique case (op_r)
            CMD_READ: begin
              res_rdata_nxt = rdata_r;
            end
            CMD_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = raddr_r + ADDR_W'(1);
              mem_wdata = rdata_r;
            end
            CMD_REMOVE: begin
              mem_we    = 1'b1;
              mem_waddr = raddr_r - ADDR_W'(1);
              mem_wdata = rdata_r;
            end
            CMD_SEARCH: begin
              if (rdata_r == key_r) begin
                found_nxt    = 1'b1;
                res_fpos_nxt = raddr_r;
                issue_nxt    = 1'b0;
                rvld_nxt     = 1'b0;
              end
            end
            CMD_SORT: begin
              // carry holds the largest entry seen so far in this pass
              if (raddr_r == '0) begin
                carry_nxt = rdata_r;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = raddr_r - ADDR_W'(1);
                if ($signed(carry_r) > $signed(rdata_r)) begin
                  mem_wdata = rdata_r;
                end else begin
                  mem_wdata = carry_r;
                  carry_nxt = rdata_r;
                end
              end
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
        if (!issue_r && !rvld_r) begin
          state_nxt = S_TAIL;
        end
      end

      S_TAIL: begin
        state_nxt = S_RESP;
        unique case (op_r)
          CMD_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_r;
            mem_wdata = key_r;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          CMD_REMOVE: begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          CMD_SEARCH: begin
            res_status_nxt = found_r ? ST_OK : ST_NOT_FOUND;
          end
          CMD_SORT: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(plen_r - CNT_W'(1));
            mem_wdata = carry_r;
            plen_nxt  = plen_r - CNT_W'(1);
            if (plen_r > CNT_W'(2)) begin
              scan_nxt  = '0;
              last_nxt  = ADDR_W'(plen_r - CNT_W'(2));
              issue_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = res_status_r;
          out_nxt.read_data      = res_rdata_r;
          out_nxt.found_position = POS_W'(res_fpos_r);
          out_nxt.entry_count    = ECNT_W'(cnt_r);
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= entry_mem_r[scan_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plen_r       <= plen_nxt;
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    scan_r       <= scan_nxt;
    last_r       <= last_nxt;
    raddr_r      <= raddr_nxt;
    carry_r      <= carry_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_fpos_r   <= res_fpos_nxt;
    out_r        <= out_nxt;
  end

`ifndef SYNTHESIS
  a_rvld_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> state_r == S_SCAN)
    else $error("read data pending outside scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> state_r != S_IDLE)
    else $error("accepted request did not start");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && (!out_valid_r || out_rsp.ready) |=>
      out_valid_r && state_r == S_IDLE)
    else $error("response not loaded");
`endif

endmodule

// ===== verif/indexed_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_tb
// Self-checking bench for the indexed list engine. A behavioral copy of the
// list predicts the response to every accepted request. Responses are
// compared field by field in order. Directed tests cover the empty list, the
// edge values, the full list and a long output stall. A random mix of fill
// and drain stretches follows, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 1640;

  logic clk;
  logic rst_n;

  ile_in_if  req_if ();
  ile_out_if rsp_if ();

  indexed_list_engine u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_rsp (rsp_if.source)
  );

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_mem [0:DEPTH-1];
  int unsigned              list_len;

  ile_rsp_t    expected_rsp_q [$];
  int unsigned error_count = 0;
  int unsigned burst_left;
  bit          no_idle;
  int unsigned hold_req;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned phase_cnt = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic ile_rsp_t predict_response(input ile_req_t req);
    ile_rsp_t                 rsp;
    int unsigned              p;
    logic signed [DATA_W-1:0] swap;
    rsp = '0;
    rsp.status = ST_OK;
    p = req.position;
    case (req.command)
      CMD_INSERT: begin
        if (p > list_len) begin
          rsp.status = ST_BAD_INDEX;
        end else if (list_len >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = req.data_value;
          list_len++;
        end
      end
      CMD_READ: begin
        if (p >= list_len) rsp.status = ST_BAD_INDEX;
        else rsp.read_data = list_mem[p];
      end
      CMD_EDIT: begin
        if (p >= list_len) rsp.status = ST_BAD_INDEX;
        else list_mem[p] = req.data_value;
      end
      CMD_REMOVE: begin
        if (p >= list_len) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        rsp.status = ST_NOT_FOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == req.data_value) begin
            rsp.status = ST_OK;
            rsp.found_position = i[POS_W-1:0];
            break;
          end
        end
      end
      CMD_SORT: begin
        for (int r = 0; r + 1 < list_len; r++) begin
          for (int i = 0; i + 1 + r < list_len; i++) begin
            if (list_mem[i] > list_mem[i+1]) begin
              swap = list_mem[i];
              list_mem[i] = list_mem[i+1];
              list_mem[i+1] = swap;
            end
          end
        end
      end
      default: ;
    endcase
    rsp.entry_count = list_len[ECNT_W-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 50) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_response(input ile_rsp_t got);
    ile_rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch("response with no request pending");
    end else begin
      want = expected_rsp_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("read_data %0d, predicted %0d",
                                  got.read_data, want.read_data));
      if (got.found_position !== want.found_position)
        report_mismatch($sformatf("found_position %0d, predicted %0d",
                                  got.found_position, want.found_position));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                  got.entry_count, want.entry_count));
    end
  endtask

  // response checking and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) check_response(rsp_if.payload);
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      phase_cnt++;
      case (ready_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
        2: rsp_if.ready <= ($urandom_range(0, 7) != 0);
        default: rsp_if.ready <= ((phase_cnt % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request or response for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic ile_req_t make_req(input command_t cmd, input int unsigned pos,
                                        input logic [DATA_W-1:0] val);
    ile_req_t req;
    req.command = cmd;
    req.position = pos[POS_W-1:0];
    req.data_value = val;
    return req;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input ile_req_t req);
    int unsigned gap;
    if (!no_idle) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    req_if.valid <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk); while (!req_if.ready);
    expected_rsp_q.push_back(predict_response(req));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_rsp_q.size() != 0);
  endtask

  task automatic test_empty_list();
    send_request(make_req(CMD_READ, 0, 32'h1234_5678));
    send_request(make_req(CMD_EDIT, 0, 32'h1));
    send_request(make_req(CMD_REMOVE, 0, 32'h0));
    send_request(make_req(CMD_SEARCH, 0, 32'h0));
    send_request(make_req(CMD_SORT, 0, 32'h0));
    send_request(make_req(CMD_INSERT, 1, 32'h7));
    wait_drained();
  endtask

  task automatic test_edge_values();
    send_request(make_req(CMD_INSERT, 0, 32'd5));
    send_request(make_req(CMD_SORT, 0, 32'h0));
    send_request(make_req(CMD_INSERT, 1, 32'h7fff_ffff));
    send_request(make_req(CMD_INSERT, 0, 32'h8000_0000));
    send_request(make_req(CMD_INSERT, 1, 32'd5));
    send_request(make_req(CMD_INSERT, 2, 32'hffff_ffff));
    send_request(make_req(CMD_SEARCH, 0, 32'd5));
    send_request(make_req(CMD_SEARCH, 0, 32'd7));
    send_request(make_req(CMD_READ, 4, 32'h0));
    send_request(make_req(CMD_READ, 5, 32'h0));
    send_request(make_req(CMD_EDIT, 0, 32'h0));
    send_request(make_req(CMD_EDIT, 5, 32'h3));
    send_request(make_req(CMD_INSERT, 6, 32'h9));
    send_request(make_req(CMD_SORT, 0, 32'h0));
    send_request(make_req(CMD_READ, 0, 32'h0));
    send_request(make_req(CMD_REMOVE, 0, 32'h0));
    send_request(make_req(CMD_REMOVE, 3, 32'h0));
    send_request(make_req(CMD_REMOVE, 3, 32'h0));
    send_request(make_req(CMD_SEARCH, 63, 32'h8000_0000));
    wait_drained();
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH)
      send_request(make_req(CMD_INSERT, $urandom_range(0, list_len), pick_value()));
    send_request(make_req(CMD_INSERT, 0, 32'h1));
    send_request(make_req(CMD_INSERT, 63, 32'h2));
    send_request(make_req(CMD_READ, 63, 32'h0));
    send_request(make_req(CMD_EDIT, 63, 32'h8000_0000));
    send_request(make_req(CMD_SEARCH, 0, 32'h8000_0000));
    send_request(make_req(CMD_SORT, 0, 32'h0));
    send_request(make_req(CMD_READ, 0, 32'h0));
    send_request(make_req(CMD_REMOVE, 63, 32'h0));
    send_request(make_req(CMD_INSERT, 63, 32'h7fff_ffff));
    send_request(make_req(CMD_READ, 63, 32'h0));
    wait_drained();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_output_stall();
    hold_req++;
    no_idle = 1'b1;
    repeat (16) begin
      if (list_len > 0)
        send_request(make_req(command_t'($urandom_range(1, 4)),
                              $urandom_range(0, list_len - 1), pick_value()));
      else
        send_request(make_req(CMD_INSERT, 0, pick_value()));
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix(input int unsigned total);
    int unsigned sent;
    int unsigned seg_left;
    int unsigned bias;
    int unsigned roll;
    int unsigned ins_share;
    int unsigned rem_share;
    int unsigned pos;
    command_t    cmd;
    logic [DATA_W-1:0] val;
    sent = 0;
    seg_left = 0;
    bias = 0;
    while (sent < total) begin
      if (seg_left == 0) begin
        bias = $urandom_range(0, 2);
        seg_left = $urandom_range(40, 160);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      case (bias)
        0: begin ins_share = 55; rem_share = 10; end
        1: begin ins_share = 15; rem_share = 45; end
        default: begin ins_share = 30; rem_share = 25; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = CMD_SORT;
      else if (roll < 2 + ins_share) cmd = CMD_INSERT;
      else if (roll < 2 + ins_share + rem_share) cmd = CMD_REMOVE;
      else cmd = command_t'($urandom_range(1, 2) + (($urandom_range(0, 2) == 0) ? 3 : 0));
      if (cmd == CMD_SORT) cmd = CMD_SEARCH;
      if (roll < 2) cmd = CMD_SORT;
      // mostly legal positions, some out of range
      if ($urandom_range(0, 9) == 0)
        pos = $urandom_range(0, 63);
      else if (cmd == CMD_INSERT)
        pos = $urandom_range(0, (list_len > 63) ? 63 : list_len);
      else if (list_len > 0)
        pos = $urandom_range(0, list_len - 1);
      else
        pos = $urandom_range(0, 63);
      if (cmd == CMD_SEARCH && list_len > 0 && $urandom_range(0, 9) < 7)
        val = list_mem[$urandom_range(0, list_len - 1)];
      else
        val = pick_value();
      send_request(make_req(cmd, pos, val));
      sent++;
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    list_len = 0;
    burst_left = 0;
    no_idle = 1'b0;
    hold_req = 0;
    rst_n <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edge_values();
    test_full_list();
    test_output_stall();
    test_random_mix(RANDOM_REQUESTS);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
